// ===== design/mzr_pkg.sv =====
// ----------------------------------------------------------------------------
// mzr_pkg
// Shared constants, types and codes for the maximal zero-rectangle finder.
// ----------------------------------------------------------------------------
`default_nettype none

package mzr_pkg;

   // Matrix size limits.
   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;

   // Derived widths.
   localparam int COL_W   = $clog2(MAX_COLS);       // column index
   localparam int CNT_W   = $clog2(MAX_COLS + 1);   // stack depth, widths, edges
   localparam int HGT_W   = $clog2(MAX_ROWS + 1);   // zero-run height
   localparam int CFG_W   = 11;                     // column_count register
   localparam int AREA_W  = 21;                     // reported area
   localparam int PROD_W  = HGT_W + CNT_W;          // height times width
   localparam int ENTRY_W = COL_W + HGT_W;          // one stack entry

   localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

   // One stack entry: the column where a bar starts and its height.
   typedef struct packed {
      logic [COL_W-1:0] idx;
      logic [HGT_W-1:0] hgt;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HCALC,
      ST_CHECK,
      ST_PUSH,
      ST_FLUSH,
      ST_POP_RD,
      ST_POP_MUL,
      ST_POP_CMP,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;         // take the item, read the column height
      logic hcalc;        // compute and store the new height
      logic push;         // push the current column
      logic pop_rd;       // read the entry below the top
      logic pop_mul;      // height times width
      logic pop_cmp;      // score the product and drop the top
      logic advance;      // step to the next column
      logic start_flush;  // row end: pop everything
      logic row_done;     // row finished, back to column zero
      logic emit;         // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic can_pop;
      logic stack_empty;
      logic row_end;
      logic flushing;
      logic last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== design/max_zero_rectangle_finder.sv =====
// ----------------------------------------------------------------------------
// max_zero_rectangle_finder
// Largest all-zero rectangle of a binary matrix streamed one cell per item.
// ----------------------------------------------------------------------------
// Usage: set the row length through csr_wr_en / csr_wr_data while the block is
// idle (it resets to one cell per row). Cells then arrive on the req_ channel
// in row-major order, one item per cell; req_last_cell marks the final cell of
// the matrix, which also closes a partial row. Exactly one item leaves on the
// rsp_ channel per matrix, carrying the area of the largest rectangle of zero
// cells. An item is taken on an edge where valid is high and stall is low.
// Steps: a cell that neither pops the stack nor ends a row goes through accept,
// height read-modify-write, stack compare and push. Each stack pop adds a
// compare, a stack read, a multiply and a score step, and the row-end flush
// runs a check, stack read, multiply and score for every entry left, plus one
// final check. Pops are bounded by pushes. The result register is loaded in
// the emit step that follows the last flush step, once the register is free.
// A new cell is taken only when the sequencer is back in idle.
// Reset clears the stack, column position and best area and sets first row;
// the height memory is not cleared, as the first row writes every column.
// A stalled result holds in its register while the next matrix is accepted;
// only a second result waits for the register to empty.
// ----------------------------------------------------------------------------
`default_nettype none

module max_zero_rectangle_finder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration
   input  wire logic                          csr_wr_en,
   input  wire logic [mzr_pkg::CFG_W-1:0]     csr_wr_data,
   // input cells
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_cell_digit,
   input  wire logic                          req_last_cell,
   // results
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [mzr_pkg::AREA_W-1:0]    rsp_max_area
);

   // The column_count register; the user must write it only while the block is idle (not enforced here).
   logic [mzr_pkg::CFG_W-1:0] column_count_ff;
   logic [mzr_pkg::CFG_W-1:0] column_count_in;

   mzr_pkg::cmd_type    cmd;
   mzr_pkg::status_type status;

   assign column_count_in = csr_wr_en ? csr_wr_data : column_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= mzr_pkg::CFG_W'(1);
      end else begin
         column_count_ff <= column_count_in;
      end
   end

   // The sequencer decides which step each cycle performs.
   mzr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Heights, the bar stack and the area arithmetic live in the datapath.
   mzr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .column_count   (column_count_ff),
      .req_cell_digit (req_cell_digit),
      .req_last_cell  (req_last_cell),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_max_area   (rsp_max_area)
   );

endmodule

`default_nettype wire

// ===== design/mzr_ram.sv =====
// ----------------------------------------------------------------------------
// mzr_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mzr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/mzr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mzr_ctrl
// Sequencer that steps one cell through height update, stack pops and push, then row flush and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module mzr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire mzr_pkg::status_type status,
   output mzr_pkg::cmd_type        cmd
);

   mzr_pkg::state_type state_ff;
   mzr_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mzr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mzr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = mzr_pkg::ST_HCALC;
            end
         end
         mzr_pkg::ST_HCALC: begin
            state_in = mzr_pkg::ST_CHECK;
         end
         mzr_pkg::ST_CHECK: begin
            if (status.can_pop) begin
               state_in = mzr_pkg::ST_POP_RD;
            end else begin
               state_in = mzr_pkg::ST_PUSH;
            end
         end
         mzr_pkg::ST_PUSH: begin
            if (status.row_end) begin
               state_in = mzr_pkg::ST_FLUSH;
            end else begin
               state_in = mzr_pkg::ST_IDLE;
            end
         end
         mzr_pkg::ST_FLUSH: begin
            if (!status.stack_empty) begin
               state_in = mzr_pkg::ST_POP_RD;
            end else if (status.last) begin
               state_in = mzr_pkg::ST_EMIT;
            end else begin
               state_in = mzr_pkg::ST_IDLE;
            end
         end
         mzr_pkg::ST_POP_RD: begin
            state_in = mzr_pkg::ST_POP_MUL;
         end
         mzr_pkg::ST_POP_MUL: begin
            state_in = mzr_pkg::ST_POP_CMP;
         end
         mzr_pkg::ST_POP_CMP: begin
            if (status.flushing) begin
               state_in = mzr_pkg::ST_FLUSH;
            end else begin
               state_in = mzr_pkg::ST_CHECK;
            end
         end
         mzr_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = mzr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mzr_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         mzr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         mzr_pkg::ST_HCALC: begin
            cmd.hcalc = 1'b1;
         end
         mzr_pkg::ST_CHECK: begin
         end
         mzr_pkg::ST_PUSH: begin
            cmd.push        = 1'b1;
            cmd.advance     = !status.row_end;
            cmd.start_flush = status.row_end;
         end
         mzr_pkg::ST_FLUSH: begin
            cmd.row_done = status.stack_empty;
         end
         mzr_pkg::ST_POP_RD: begin
            cmd.pop_rd = 1'b1;
         end
         mzr_pkg::ST_POP_MUL: begin
            cmd.pop_mul = 1'b1;
         end
         mzr_pkg::ST_POP_CMP: begin
            cmd.pop_cmp = 1'b1;
         end
         mzr_pkg::ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/mzr_datapath.sv =====
// ----------------------------------------------------------------------------
// mzr_datapath
// Column heights, bar stack, area multiplier, best area and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mzr_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mzr_pkg::cmd_type              cmd,
   output mzr_pkg::status_type                status,
   input  wire logic [mzr_pkg::CFG_W-1:0]     column_count,
   input  wire logic                          req_cell_digit,
   input  wire logic                          req_last_cell,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output logic      [mzr_pkg::AREA_W-1:0]    rsp_max_area
);

   localparam int COL_W  = mzr_pkg::COL_W;
   localparam int CNT_W  = mzr_pkg::CNT_W;
   localparam int HGT_W  = mzr_pkg::HGT_W;
   localparam int CFG_W  = mzr_pkg::CFG_W;
   localparam int AREA_W = mzr_pkg::AREA_W;
   localparam int PROD_W = mzr_pkg::PROD_W;

   // Control state.
   logic [COL_W-1:0]  pos_ff,       pos_in;
   logic              first_row_ff, first_row_in;
   logic [CNT_W-1:0]  depth_ff,     depth_in;
   logic              flush_ff,     flush_in;
   logic [AREA_W-1:0] best_ff,      best_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload.
   logic               digit_ff,    digit_in;
   logic               last_ff,     last_in;
   logic [HGT_W-1:0]   h_ff,        h_in;
   mzr_pkg::entry_type top_ff,      top_in;
   logic [PROD_W-1:0]  prod_ff,     prod_in;
   logic [AREA_W-1:0]  rsp_area_ff, rsp_area_in;

   logic [HGT_W-1:0]   hgt_rd_data;
   logic [HGT_W-1:0]   h_calc;
   mzr_pkg::entry_type below;
   logic [mzr_pkg::ENTRY_W-1:0] stack_rd_data;
   logic [CNT_W-1:0]   depth_m1;
   logic [CNT_W-1:0]   depth_m2;
   logic [CNT_W-1:0]   pos_p1;
   logic [CNT_W-1:0]   edge_col;
   logic [CNT_W-1:0]   bar_width;
   logic [CNT_W-1:0]   cols;
   logic [AREA_W-1:0]  area_sat;
   logic               out_free;

   assign below    = mzr_pkg::entry_type'(stack_rd_data);
   assign depth_m1 = depth_ff - CNT_W'(1);
   assign depth_m2 = depth_ff - CNT_W'(2);
   assign pos_p1   = CNT_W'(pos_ff) + CNT_W'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Row length in force: zero acts as one, too large acts as the maximum.
   always_comb begin
      if (column_count == '0) begin
         cols = CNT_W'(1);
      end else if (column_count > CFG_W'(mzr_pkg::MAX_COLS)) begin
         cols = CNT_W'(mzr_pkg::MAX_COLS);
      end else begin
         cols = CNT_W'(column_count);
      end
   end

   // New height of the current column; it saturates at the row limit.
   always_comb begin
      if (digit_ff) begin
         h_calc = '0;
      end else if (first_row_ff) begin
         h_calc = HGT_W'(1);
      end else if (hgt_rd_data >= HGT_W'(mzr_pkg::MAX_ROWS)) begin
         h_calc = HGT_W'(mzr_pkg::MAX_ROWS);
      end else begin
         h_calc = hgt_rd_data + HGT_W'(1);
      end
   end

   // The bar ends just before the current column, or after it at row end.
   always_comb begin
      edge_col = flush_ff ? pos_p1 : CNT_W'(pos_ff);
      if (depth_ff == CNT_W'(1)) begin
         bar_width = edge_col;
      end else begin
         bar_width = edge_col - CNT_W'(below.idx) - CNT_W'(1);
      end
   end

   assign area_sat = (prod_ff > PROD_W'(mzr_pkg::AREA_MAX)) ? mzr_pkg::AREA_MAX
                                                          : prod_ff[AREA_W-1:0];

   always_comb begin
      pos_in       = pos_ff;
      first_row_in = first_row_ff;
      depth_in     = depth_ff;
      flush_in     = flush_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff;
      digit_in     = digit_ff;
      last_in      = last_ff;
      h_in         = h_ff;
      top_in       = top_ff;
      prod_in      = prod_ff;
      rsp_area_in  = rsp_area_ff;

      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         digit_in = req_cell_digit;
         last_in  = req_last_cell;
      end
      if (cmd.hcalc) begin
         h_in = h_calc;
      end
      if (cmd.push) begin
         top_in.idx = pos_ff;
         top_in.hgt = h_ff;
         depth_in   = depth_ff + CNT_W'(1);
      end
      if (cmd.pop_mul) begin
         prod_in = PROD_W'(top_ff.hgt) * PROD_W'(bar_width);
      end
      if (cmd.pop_cmp) begin
         if (area_sat > best_ff) begin
            best_in = area_sat;
         end
         top_in   = below;
         depth_in = depth_m1;
      end
      if (cmd.advance) begin
         pos_in = pos_ff + COL_W'(1);
      end
      if (cmd.start_flush) begin
         flush_in = 1'b1;
      end
      if (cmd.row_done) begin
         flush_in = 1'b0;
         pos_in   = '0;
         if (!last_ff) begin
            first_row_in = 1'b0;
         end
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_area_in  = best_ff;
         best_in      = '0;
         first_row_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         first_row_ff <= 1'b1;
         depth_ff     <= '0;
         flush_ff     <= 1'b0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         first_row_ff <= first_row_in;
         depth_ff     <= depth_in;
         flush_ff     <= flush_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff    <= digit_in;
      last_ff     <= last_in;
      h_ff        <= h_in;
      top_ff      <= top_in;
      prod_ff     <= prod_in;
      rsp_area_ff <= rsp_area_in;
   end

   // Height of every column, read when an item arrives, written back in the following cycle.
   mzr_ram #(
      .WIDTH (HGT_W),
      .DEPTH (mzr_pkg::MAX_COLS)
   ) u_heights (
      .clock   (clock),
      .wr_en   (cmd.hcalc),
      .wr_addr (pos_ff),
      .wr_data (h_calc),
      .rd_en   (cmd.load),
      .rd_addr (pos_ff),
      .rd_data (hgt_rd_data)
   );

   // Stack entries below the top; the top entry lives in top_ff.
   mzr_ram #(
      .WIDTH (mzr_pkg::ENTRY_W),
      .DEPTH (mzr_pkg::MAX_COLS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push && (depth_ff != '0)),
      .wr_addr (depth_m1[COL_W-1:0]),
      .wr_data (top_ff),
      .rd_en   (cmd.pop_rd),
      .rd_addr (depth_m2[COL_W-1:0]),
      .rd_data (stack_rd_data)
   );

   assign status.can_pop     = (depth_ff != '0) && (top_ff.hgt >= h_ff);
   assign status.stack_empty = (depth_ff == '0);
   assign status.row_end     = last_ff || (pos_p1 >= cols);
   assign status.flushing    = flush_ff;
   assign status.last        = last_ff;
   assign status.out_free    = out_free;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_max_area = rsp_area_ff;

endmodule

`default_nettype wire

// ===== design/mzr_checker.sv =====
// ----------------------------------------------------------------------------
// mzr_checker
// Port-level checks for the maximal zero-rectangle finder.
// ----------------------------------------------------------------------------
`default_nettype none

module mzr_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          csr_wr_en,
   input wire logic [mzr_pkg::CFG_W-1:0]     csr_wr_data,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          req_cell_digit,
   input wire logic                          req_last_cell,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [mzr_pkg::AREA_W-1:0]    rsp_max_area
);

   logic req_take;

   assign req_take = req_valid && !req_stall;

   // A result waiting on a stall keeps its value.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_max_area))
      else $error("result changed while stalled");

   // Every accepted cell keeps the block busy for its height and compare steps.
   a_busy_after_take : assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall ##1 req_stall)
      else $error("cell accepted too early after the previous one");

   // No rectangle can exceed the full matrix size.
   a_area_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_max_area <= mzr_pkg::AREA_W'(1048576))
      else $error("reported area out of range");

   // Reset leaves no result pending.
   a_reset_clear : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind max_zero_rectangle_finder mzr_checker u_checker (.*);

`default_nettype wire

// ===== sim/mzr_area_checker.sv =====
// ----------------------------------------------------------------------------
// mzr_area_checker
// Watches the cell and area channels, predicts every area and compares it.
// ----------------------------------------------------------------------------
// The predictor follows the column heights, the stack of open bars and the
// best area in its own state. It also tracks the row length register from the
// writes it sees on the csr_ port.
// ----------------------------------------------------------------------------

module mzr_area_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [mzr_pkg::CFG_W-1:0]     csr_wr_data,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic                          req_cell_digit,
   input  wire logic                          req_last_cell,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [mzr_pkg::AREA_W-1:0]    rsp_max_area,
   output int                                 area_failures,
   output int                                 areas_pending,
   output int                                 areas_checked
);

   logic [mzr_pkg::CFG_W-1:0]  row_length;
   bit   [mzr_pkg::HGT_W-1:0]  zrun_height [mzr_pkg::MAX_COLS];
   bit   [mzr_pkg::COL_W-1:0]  bar_stack [mzr_pkg::MAX_COLS];
   int                         bar_depth;
   logic [mzr_pkg::COL_W-1:0]  col_pos;
   logic                       top_row;
   logic [mzr_pkg::AREA_W-1:0] largest_area;
   logic [mzr_pkg::AREA_W-1:0] area_queue [$];
   logic [mzr_pkg::AREA_W-1:0] want_area;

   // Close the bar on top of the stack; its right bound is exclusive.
   task automatic close_bar(input int right_bound);
      int     top_col;
      int     span;
      longint prod;
      top_col = int'(bar_stack[bar_depth-1]);
      bar_depth--;
      if (bar_depth == 0) begin
         span = right_bound;
      end else begin
         span = right_bound - int'(bar_stack[bar_depth-1]) - 1;
      end
      prod = longint'(zrun_height[top_col]) * span;
      if (prod > longint'(mzr_pkg::AREA_MAX)) begin
         prod = longint'(mzr_pkg::AREA_MAX);
      end
      if (prod > longint'(largest_area)) begin
         largest_area = prod[mzr_pkg::AREA_W-1:0];
      end
   endtask

   // Advance the predictor by one cell; the last cell queues an area.
   task automatic predict_cell(input logic digit, input logic last);
      int eff_cols;
      int pos;
      int h;
      bit row_end;
      eff_cols = int'(row_length);
      if (eff_cols == 0) begin
         eff_cols = 1;
      end
      if (eff_cols > mzr_pkg::MAX_COLS) begin
         eff_cols = mzr_pkg::MAX_COLS;
      end
      pos = int'(col_pos);
      if (digit) begin
         h = 0;
      end else if (top_row) begin
         h = 1;
      end else begin
         h = int'(zrun_height[pos]) + 1;
         if (h > mzr_pkg::MAX_ROWS) begin
            h = mzr_pkg::MAX_ROWS;
         end
      end
      zrun_height[pos] = mzr_pkg::HGT_W'(h);
      while (bar_depth > 0 && int'(zrun_height[bar_stack[bar_depth-1]]) >= h &&
             int'(bar_stack[bar_depth-1]) != pos) begin
         close_bar(pos);
      end
      if (bar_depth < mzr_pkg::MAX_COLS) begin
         bar_stack[bar_depth] = mzr_pkg::COL_W'(pos);
         bar_depth++;
      end
      row_end = last || (pos + 1 >= eff_cols);
      if (!row_end) begin
         col_pos = mzr_pkg::COL_W'(pos + 1);
         return;
      end
      while (bar_depth > 0) begin
         close_bar(pos + 1);
      end
      col_pos = '0;
      if (!last) begin
         top_row = 1'b0;
         return;
      end
      area_queue.push_back(largest_area);
      largest_area = '0;
      top_row = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         row_length   = mzr_pkg::CFG_W'(1);
         bar_depth    = 0;
         col_pos      = '0;
         top_row      = 1'b1;
         largest_area = '0;
         area_queue.delete();
      end else begin
         if (csr_wr_en) begin
            row_length = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            predict_cell(req_cell_digit, req_last_cell);
         end
         if (rsp_valid && !rsp_stall) begin
            if (area_queue.size() == 0) begin
               $error("max_area %0d arrived with no area expected", rsp_max_area);
               area_failures++;
            end else begin
               want_area = area_queue.pop_front();
               areas_checked++;
               if (rsp_max_area !== want_area) begin
                  $error("max_area mismatch: expected %0d, actual %0d",
                         want_area, rsp_max_area);
                  area_failures++;
               end
            end
         end
      end
      areas_pending = area_queue.size();
   end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the maximal zero-rectangle finder.
// ----------------------------------------------------------------------------
// Streams binary matrices into the block cell by cell and lets the area
// checker predict and compare each reported area. A short directed part hits
// the corner cases; random matrices of many row lengths follow, under three
// idle profiles, with one long result back-pressure stretch.
// ----------------------------------------------------------------------------

module tb_top;

   // Longest stretch without any handshake before the run is declared hung.
   // The worst legal gap is the long result hold, next a 40-cell row flush
   // under random result stalls, so this leaves a wide margin.
   localparam int QUIET_LIMIT = 4000;
   // Length of the forced result hold that fills the block up.
   localparam int HOLD_CYCLES = 300;
   // Random cells per idle profile.
   localparam int PHASE_CELLS = 180;

   logic                          clock        = 1'b0;
   logic                          reset        = 1'b1;
   logic                          csr_wr_en    = 1'b0;
   logic [mzr_pkg::CFG_W-1:0]     csr_wr_data  = '0;
   logic                          req_valid    = 1'b0;
   logic                          req_stall;
   logic                          req_cell_digit = 1'b0;
   logic                          req_last_cell  = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall    = 1'b0;
   logic [mzr_pkg::AREA_W-1:0]    rsp_max_area;

   int area_failures;
   int areas_pending;
   int areas_checked;

   // Idle rates in percent. The receiver rate and the hold ticket are
   // written with nonblocking assignments so the receiver process, which
   // also runs at the falling edge, always sees last cycle's value.
   int send_idle_pct = 9;
   int rsp_idle_pct  = 58;
   int hold_ticket   = 0;

   // Row length currently programmed, as the stimulus sees it.
   int row_length = 1;
   int cells_sent = 0;
   int matrices_sent = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   max_zero_rectangle_finder dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cell_digit (req_cell_digit),
      .req_last_cell  (req_last_cell),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_max_area   (rsp_max_area)
   );

   mzr_area_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cell_digit (req_cell_digit),
      .req_last_cell  (req_last_cell),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_max_area   (rsp_max_area),
      .area_failures  (area_failures),
      .areas_pending  (areas_pending),
      .areas_checked  (areas_checked)
   );

   // Result side. Each new hold ticket starts a long stall that this process
   // counts down itself; otherwise it stalls at random at the current rate.
   int hold_seen = 0;
   int hold_left = 0;

   always @(negedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen = hold_ticket;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // Watchdog: any accepted item on either channel restarts the count.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("tb_top: FAIL");
      $finish;
   end

   // Row length after the block clamps the register value.
   function automatic int effective_columns(input int value);
      if (value == 0) begin
         return 1;
      end
      if (value > mzr_pkg::MAX_COLS) begin
         return mzr_pkg::MAX_COLS;
      end
      return value;
   endfunction

   // Offer one cell and wait until it is accepted. Valid is left high on
   // return, so back-to-back cells never drop it within one time step; the
   // idle loop or a drain lowers it when needed. Called and returns at a
   // falling edge.
   task automatic send_cell(input logic digit, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cell_digit <= digit;
      req_last_cell  <= last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
      cells_sent++;
      if (last) begin
         matrices_sent++;
      end
   endtask

   // Send a row written as a string of digits; optionally flag its final
   // cell as the last cell of the matrix.
   task automatic send_row(input string pattern, input bit ends_matrix);
      for (int i = 0; i < pattern.len(); i++) begin
         send_cell(pattern[i] == "1", ends_matrix && (i == pattern.len() - 1));
      end
   endtask

   // A random matrix of the current row length. zero_pct sets how dense the
   // zero cells are; cut_short ends the matrix inside its last row.
   task automatic send_matrix(input int rows, input int zero_pct, input bit cut_short);
      int eff;
      int row_cells;
      eff = effective_columns(row_length);
      for (int r = 0; r < rows; r++) begin
         row_cells = eff;
         if (cut_short && r == rows - 1) begin
            row_cells = $urandom_range(1, eff);
         end
         for (int c = 0; c < row_cells; c++) begin
            send_cell($urandom_range(0, 99) >= zero_pct,
                      (r == rows - 1) && (c == row_cells - 1));
         end
      end
   endtask

   // Stop offering cells, wait for every predicted area to come back, then
   // let the block finish any cell that produces no area.
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      @(negedge clock);
      while (areas_pending != 0) begin
         @(negedge clock);
      end
      repeat (settle) @(negedge clock);
   endtask

   // Program the row length once the block is quiet. A cell in flight can
   // still be working through its stack pops, so settle is sized for that.
   task automatic reconfigure(input int value, input int settle);
      drain(settle);
      csr_wr_data <= mzr_pkg::CFG_W'(value);
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
      row_length = value;
   endtask

   initial begin
      int phase_start;
      int pick;
      int zero_pct;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---------------- directed part ----------------
      // The reset row length is one cell: a lone zero and a lone one.
      send_cell(1'b0, 1'b1);
      send_cell(1'b1, 1'b1);

      // A small matrix whose best rectangle spans rows of different heights.
      reconfigure(4, 16);
      send_row("0010", 1'b0);
      send_row("0000", 1'b0);
      send_row("1000", 1'b1);

      // A row length of zero acts as one cell per row.
      reconfigure(0, 16);
      send_row("001", 1'b1);

      // The last cell arrives in the middle of a row.
      reconfigure(3, 16);
      send_row("010", 1'b0);
      send_row("0", 1'b1);

      // The row length shrinks in the middle of a matrix. Only narrowing is
      // done, so no row ever reads a column height that was never written.
      reconfigure(5, 16);
      send_row("00000", 1'b0);
      send_row("00", 1'b0);
      reconfigure(2, 8 * 5 + 16);
      send_row("0", 1'b0);
      send_row("00", 1'b1);

      // A single column of zeros taller than the height limit saturates.
      reconfigure(1, 16);
      send_matrix(mzr_pkg::MAX_ROWS + 6, 100, 1'b0);

      // A register value past the column limit still gives one long row.
      reconfigure(2047, 16);
      send_row("0010000100", 1'b1);

      // ---------------- random part ----------------
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 9;
               rsp_idle_pct <= 58;
            end
            1: begin
               send_idle_pct = 58;
               rsp_idle_pct <= 9;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct <= 0;
               // Hold the result side for a long stretch while one-cell
               // matrices keep coming, so the block backs up and stalls.
               reconfigure(1, 16);
               hold_ticket <= hold_ticket + 1;
               repeat (12) send_cell(1'($urandom_range(0, 1)), 1'b1);
            end
         endcase
         phase_start = cells_sent;
         while (cells_sent - phase_start < PHASE_CELLS) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               reconfigure(0, 16);
            end else if (pick < 80) begin
               reconfigure($urandom_range(1, 8), 16);
            end else begin
               reconfigure($urandom_range(9, 40), 16);
            end
            repeat ($urandom_range(2, 6)) begin
               case ($urandom_range(0, 3))
                  0:       zero_pct = 50;
                  1:       zero_pct = 75;
                  2:       zero_pct = 90;
                  default: zero_pct = 100;
               endcase
               send_matrix($urandom_range(1, 6), zero_pct, $urandom_range(0, 3) == 0);
            end
         end
      end

      // Let every area come home, then a few more cycles for stray output.
      drain(24);

      $display("Run covered %0d cells in %0d matrices; %0d areas compared.",
               cells_sent, matrices_sent, areas_checked);
      $display("Row lengths 0 to 2047, height saturation, cut-short rows and back-pressure.");
      if (area_failures == 0 && areas_pending == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
